// ===== rtl/lct_pkg.sv =====
// lct_pkg: shared types and constants for the linked chain table.
// No dependencies; imported by lct_ram users and linked_chain_table_top.
package lct_pkg;

	localparam int CARS_DEF = 64;
	localparam int IDX_W    = 6;

	localparam logic [1:0] FUNC_LINK   = 2'd0;
	localparam logic [1:0] FUNC_UNLINK = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;

	typedef struct packed {
		logic [1:0]       func;
		logic [IDX_W-1:0] car_a;
		logic [IDX_W-1:0] car_b;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] car_index;
		logic             last;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HEAD,
		ST_TAIL
	} state_t;

endpackage

// ===== rtl/lct_ram.sv =====
// lct_ram: generic single-write, single-read RAM with registered read data.
// No package dependencies.
module lct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/linked_chain_table_top.sv =====
// linked_chain_table_top: table of entries with predecessor and successor links.
// Depends on lct_pkg and lct_ram.
//
// Each of CARS entries may hold a predecessor and a successor link; all are
// unlinked after reset (per-entry valid flags in flops, link indices in two
// RAMs). A link transfer (func link) makes car_a the predecessor of car_b and
// car_b the successor of car_a, overwriting earlier links without fixing up
// former partners; an unlink transfer clears both. Either is ignored when an
// entry is out of range, and func 3 is ignored. A query transfer walks
// predecessor links from car_a to the head of its chain, then walks successor
// links emitting one rsp transfer per entry, head first, with last set on the
// tail. Each walk is capped at CARS steps; the final emitted entry carries
// last even if it still has a successor. A query on an out-of-range entry
// emits nothing.
// Link, unlink and ignored transfers never raise req_stall. A query holds
// req_stall high through ST_HEAD, which makes H predecessor hops (at most
// CARS), and ST_TAIL, which emits N entries (at most CARS) and waits while
// rsp_stall holds the output register. Both walks run on the single shared
// step unit: one link-RAM read and one index compare per cycle, save while
// rsp_stall holds the output register, the RAM read address being the
// next walk position so that its registered data is ready each cycle.
// The last result may still sit in the output register while the next
// request is taken.
module linked_chain_table_top #(
	parameter int CARS = lct_pkg::CARS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lct_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lct_pkg::rsp_t rsp
);

	import lct_pkg::*;

	localparam int AW = (CARS > 1) ? $clog2(CARS) : 1;   // RAM address width
	localparam int CW = $clog2(CARS + 1);                // step counter width

	state_t          state_q, state_d;
	logic [AW-1:0]   cur_q, cur_d;         // current walk position
	logic [CW-1:0]   steps_q, steps_d;     // hops taken / entries emitted
	logic [CARS-1:0] pred_v_q, succ_v_q;   // link valid flags
	logic [AW-1:0]   pred_rdata, succ_rdata;
	rsp_t            rsp_q;
	logic            rsp_valid_q;

	logic accept, a_ok, b_ok, link_acc, unlink_acc, query_acc;
	logic head_more, tail_more, slot_free, emit;

	// request decode
	assign accept     = req_valid && !req_stall;
	assign a_ok       = ((IDX_W+1)'(req.car_a) < (IDX_W+1)'(CARS));
	assign b_ok       = ((IDX_W+1)'(req.car_b) < (IDX_W+1)'(CARS));
	assign link_acc   = accept && (req.func == FUNC_LINK) && a_ok && b_ok;
	assign unlink_acc = accept && (req.func == FUNC_UNLINK) && a_ok && b_ok;
	assign query_acc  = accept && (req.func == FUNC_QUERY) && a_ok;

	// shared step unit: one valid check and one limit compare per cycle
	assign head_more = pred_v_q[cur_q] && (steps_q != CW'(CARS));
	assign tail_more = succ_v_q[cur_q] && (steps_q != CW'(CARS - 1));
	assign slot_free = !rsp_valid_q || !rsp_stall;

	// link RAMs; both read at the next walk position
	lct_ram #(.WIDTH(AW), .DEPTH(CARS)) u_pred_ram (
		.clk   (clk),
		.we    (link_acc),
		.waddr (req.car_b[AW-1:0]),
		.wdata (req.car_a[AW-1:0]),
		.raddr (cur_d),
		.rdata (pred_rdata)
	);

	lct_ram #(.WIDTH(AW), .DEPTH(CARS)) u_succ_ram (
		.clk   (clk),
		.we    (link_acc),
		.waddr (req.car_a[AW-1:0]),
		.wdata (req.car_b[AW-1:0]),
		.raddr (cur_d),
		.rdata (succ_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (query_acc) state_d = ST_HEAD;
			end
			ST_HEAD: begin
				if (!head_more) state_d = ST_TAIL;
			end
			ST_TAIL: begin
				if (emit && !tail_more) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and walk datapath
	always_comb begin
		req_stall = (state_q != ST_IDLE);
		emit      = 1'b0;
		cur_d     = cur_q;
		steps_d   = steps_q;
		case (state_q)
			ST_IDLE: begin
				if (query_acc) begin
					cur_d   = req.car_a[AW-1:0];
					steps_d = '0;
				end
			end
			ST_HEAD: begin
				if (head_more) begin
					cur_d   = pred_rdata;
					steps_d = steps_q + CW'(1);
				end else begin
					steps_d = '0;
				end
			end
			ST_TAIL: begin
				emit = slot_free;
				if (slot_free && tail_more) begin
					cur_d   = succ_rdata;
					steps_d = steps_q + CW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			steps_q     <= '0;
			pred_v_q    <= '0;
			succ_v_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cur_q   <= cur_d;
			steps_q <= steps_d;
			if (link_acc || unlink_acc) begin
				pred_v_q[req.car_b[AW-1:0]] <= link_acc;
				succ_v_q[req.car_a[AW-1:0]] <= link_acc;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q.car_index <= IDX_W'(cur_q);
			rsp_q.last      <= !tail_more;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
